>>> hdl/tgrt_pkg.sv
package tgrt_pkg;

    // Width of the time fields on the result channel
    localparam int unsigned OUT_TIME_W = 32;

    // Configuration register widths and reset values
    localparam int unsigned LOCKOUT_W  = 16;
    localparam int unsigned TIMEOUT_W  = 32;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd100;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd300000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_LOCKOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'b1;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_READY   = 2'd0;
    localparam t_mode MODE_RUNNING = 2'd1;
    localparam t_mode MODE_RESULT  = 2'd2;
    localparam t_mode MODE_BEST    = 2'd3;

    // Pending gate events
    localparam logic [1:0] PEND_NONE   = 2'b00;
    localparam logic [1:0] PEND_START  = 2'b01;
    localparam logic [1:0] PEND_FINISH = 2'b10;

    typedef struct packed {
        logic start_gate;
        logic finish_gate;
        logic show_button;
        logic clear_button;
        logic sleep_button;
    } t_item;

    // Control state of the mode machine
    typedef struct packed {
        t_mode      mode;
        logic       prev_valid;
        t_mode      prev_mode;
        logic [1:0] pend;
        logic [2:0] btn_prev;   // sleep, clear, show
    } t_ctrl;

    typedef struct packed {
        t_mode                 mode;
        logic [OUT_TIME_W-1:0] shown_time_ms;
        logic [OUT_TIME_W-1:0] best_time_ms;
        logic                  refresh;
        logic                  sleep_request;
    } t_result;

endpackage

>>> hdl/tgrt_in_if.sv
interface tgrt_in_if;
    logic valid;
    logic ready;
    logic start_gate;
    logic finish_gate;
    logic show_button;
    logic clear_button;
    logic sleep_button;

    modport source (
        output valid, start_gate, finish_gate, show_button, clear_button, sleep_button,
        input  ready
    );

    modport sink (
        input  valid, start_gate, finish_gate, show_button, clear_button, sleep_button,
        output ready
    );
endinterface

>>> hdl/tgrt_out_if.sv
interface tgrt_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       mode;
    logic [tgrt_pkg::OUT_TIME_W-1:0] shown_time_ms;
    logic [tgrt_pkg::OUT_TIME_W-1:0] best_time_ms;
    logic                             refresh;
    logic                             sleep_request;

    modport source (
        output valid, mode, shown_time_ms, best_time_ms, refresh, sleep_request,
        input  ready
    );

    modport sink (
        input  valid, mode, shown_time_ms, best_time_ms, refresh, sleep_request,
        output ready
    );
endinterface

>>> hdl/two_gate_race_timer.sv
// Two-gate race timer with best-time memory.
//
// i_item carries one beat per millisecond tick: the start and finish gate
// pulses and the levels of the show, clear and sleep buttons. o_result
// returns exactly one beat per input beat: the mode, the time to show, the
// stored best time (zero means none) and the refresh and sleep pulses.
// The configuration port writes the gate lockout (index 0) and the idle
// timeout (index 1) through i_cfg_we / i_cfg_index / i_cfg_data; write them
// only while no beat is in flight.
//
// A beat lands in the input register, is evaluated by the combinational step
// logic and moves into the result register together with the state update.
// One beat is taken every cycle while the receiver does not stall; the state
// feedback through the step logic sets that rate. When the receiver stalls,
// the result register holds and the input register fills; i_item.ready falls
// only when both are full. Reset clears the tick counter, all times, the mode
// (ready), the pending gate events and the button history, and restores both
// configuration registers to their defaults (100 ms lockout, 300000 ms
// timeout).
module two_gate_race_timer #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tgrt_in_if.sink                             i_item,
    tgrt_out_if.source                          o_result,
    input  logic                                i_cfg_we,
    input  logic [tgrt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tgrt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration
    logic [tgrt_pkg::LOCKOUT_W-1:0] r_lockout;
    logic [tgrt_pkg::TIMEOUT_W-1:0] r_idle_timeout;

    // Input stage
    logic            r_in_valid;
    tgrt_pkg::t_item r_in;

    // Timer state
    logic [TIME_WIDTH-1:0] r_tick;
    tgrt_pkg::t_ctrl       r_ctrl;
    logic [TIME_WIDTH-1:0] r_start_time;
    logic [TIME_WIDTH-1:0] r_last_result;
    logic [TIME_WIDTH-1:0] r_best;
    logic [TIME_WIDTH-1:0] r_last_gate;
    logic [TIME_WIDTH-1:0] r_last_act;

    // Result stage
    logic              r_out_valid;
    tgrt_pkg::t_result r_out;

    // Step results
    tgrt_pkg::t_ctrl       n_ctrl;
    logic [TIME_WIDTH-1:0] n_start_time;
    logic [TIME_WIDTH-1:0] n_last_result;
    logic [TIME_WIDTH-1:0] n_best;
    logic [TIME_WIDTH-1:0] n_last_gate;
    logic [TIME_WIDTH-1:0] n_last_act;
    tgrt_pkg::t_result     n_out;

    logic advance;
    logic in_take;

    // Evaluate the held beat when the result register is free or draining
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || advance;
    assign in_take        = i_item.valid && i_item.ready;

    tgrt_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .i_item         (r_in),
        .i_ctrl         (r_ctrl),
        .i_tick         (r_tick),
        .i_start_time   (r_start_time),
        .i_last_result  (r_last_result),
        .i_best         (r_best),
        .i_last_gate    (r_last_gate),
        .i_last_act     (r_last_act),
        .i_lockout      (r_lockout),
        .i_idle_timeout (r_idle_timeout),
        .o_ctrl         (n_ctrl),
        .o_start_time   (n_start_time),
        .o_last_result  (n_last_result),
        .o_best         (n_best),
        .o_last_gate    (n_last_gate),
        .o_last_act     (n_last_act),
        .o_result       (n_out)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout      <= tgrt_pkg::LOCKOUT_RESET;
            r_idle_timeout <= tgrt_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tgrt_pkg::CFG_GATE_LOCKOUT: r_lockout      <= i_cfg_data[tgrt_pkg::LOCKOUT_W-1:0];
                tgrt_pkg::CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data[tgrt_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: capture a beat whenever the stage is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.start_gate   <= i_item.start_gate;
            r_in.finish_gate  <= i_item.finish_gate;
            r_in.show_button  <= i_item.show_button;
            r_in.clear_button <= i_item.clear_button;
            r_in.sleep_button <= i_item.sleep_button;
        end
    end

    // Timer state: advance one tick per evaluated beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_ctrl        <= '{mode: tgrt_pkg::MODE_READY, prev_valid: 1'b0,
                               prev_mode: tgrt_pkg::MODE_READY,
                               pend: tgrt_pkg::PEND_NONE, btn_prev: 3'b000};
            r_start_time  <= '0;
            r_last_result <= '0;
            r_best        <= '0;
            r_last_gate   <= '0;
            r_last_act    <= '0;
        end else if (advance) begin
            r_tick        <= r_tick + TIME_WIDTH'(1);
            r_ctrl        <= n_ctrl;
            r_start_time  <= n_start_time;
            r_last_result <= n_last_result;
            r_best        <= n_best;
            r_last_gate   <= n_last_gate;
            r_last_act    <= n_last_act;
        end
    end

    // Result register: load on evaluate, drop on handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.mode          = r_out.mode;
    assign o_result.shown_time_ms = r_out.shown_time_ms;
    assign o_result.best_time_ms  = r_out.best_time_ms;
    assign o_result.refresh       = r_out.refresh;
    assign o_result.sleep_request = r_out.sleep_request;

    // A sleep always lands in ready and always redraws
    a_sleep_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.sleep_request |->
            o_result.mode == tgrt_pkg::MODE_READY && o_result.refresh)
        else $error("sleep beat not in ready mode or without refresh");

    // Ready mode shows a blank time
    a_ready_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.mode == tgrt_pkg::MODE_READY |->
            o_result.shown_time_ms == '0)
        else $error("ready mode shows a nonzero time");

    // Running mode redraws every tick
    a_running_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.mode == tgrt_pkg::MODE_RUNNING |-> o_result.refresh)
        else $error("running mode without refresh");

    // Each evaluated beat advances time by exactly one tick
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_tick == TIME_WIDTH'($past(r_tick) + 1'b1))
        else $error("tick counter did not advance by one");

    // An evaluated beat always leaves a result waiting
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("evaluated beat left no result");

endmodule

>>> hdl/tgrt_step.sv
module tgrt_step #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  tgrt_pkg::t_item                   i_item,
    input  tgrt_pkg::t_ctrl                   i_ctrl,
    input  logic [TIME_WIDTH-1:0]             i_tick,
    input  logic [TIME_WIDTH-1:0]             i_start_time,
    input  logic [TIME_WIDTH-1:0]             i_last_result,
    input  logic [TIME_WIDTH-1:0]             i_best,
    input  logic [TIME_WIDTH-1:0]             i_last_gate,
    input  logic [TIME_WIDTH-1:0]             i_last_act,
    input  logic [tgrt_pkg::LOCKOUT_W-1:0]    i_lockout,
    input  logic [tgrt_pkg::TIMEOUT_W-1:0]    i_idle_timeout,
    output tgrt_pkg::t_ctrl                   o_ctrl,
    output logic [TIME_WIDTH-1:0]             o_start_time,
    output logic [TIME_WIDTH-1:0]             o_last_result,
    output logic [TIME_WIDTH-1:0]             o_best,
    output logic [TIME_WIDTH-1:0]             o_last_gate,
    output logic [TIME_WIDTH-1:0]             o_last_act,
    output tgrt_pkg::t_result                 o_result
);

    // Common width for the idle compare and the result fields
    localparam int unsigned CW = (TIME_WIDTH > tgrt_pkg::TIMEOUT_W) ?
                                 TIME_WIDTH : tgrt_pkg::TIMEOUT_W;

    always_comb begin
        logic [TIME_WIDTH-1:0] now;
        logic [TIME_WIDTH-1:0] gate_gap;
        logic [TIME_WIDTH-1:0] idle_gap;
        logic [TIME_WIDTH-1:0] start_t;
        logic [TIME_WIDTH-1:0] last_res;
        logic [TIME_WIDTH-1:0] best;
        logic [TIME_WIDTH-1:0] last_gate;
        logic [TIME_WIDTH-1:0] last_act;
        logic [TIME_WIDTH-1:0] shown;
        logic [CW-1:0]         shown_ext;
        logic [CW-1:0]         best_ext;
        logic                  gate_open;
        logic                  sg_ok;
        logic                  fg_ok;
        logic                  show_edge;
        logic                  clear_edge;
        logic                  sleep_edge;
        logic                  first;
        logic                  refresh;
        logic                  sleep_req;
        logic [1:0]            pend;
        tgrt_pkg::t_mode       mode;

        now       = i_tick;
        start_t   = i_start_time;
        last_res  = i_last_result;
        best      = i_best;
        last_gate = i_last_gate;
        last_act  = i_last_act;
        pend      = i_ctrl.pend;

        // Gates: an accepted start closes the lockout for a finish in the same tick
        gate_gap  = now - i_last_gate;
        gate_open = gate_gap > TIME_WIDTH'(i_lockout);
        sg_ok     = i_item.start_gate && gate_open;
        fg_ok     = i_item.finish_gate && gate_open && !sg_ok;

        if (sg_ok) begin
            pend      = tgrt_pkg::PEND_START;
            start_t   = now;
            last_gate = now;
        end
        if (fg_ok) begin
            pend      = pend | tgrt_pkg::PEND_FINISH;
            last_res  = now - i_start_time;
            last_gate = now;
        end

        show_edge  = i_item.show_button  && !i_ctrl.btn_prev[0];
        clear_edge = i_item.clear_button && !i_ctrl.btn_prev[1];
        sleep_edge = !i_item.sleep_button && i_ctrl.btn_prev[2];

        first     = !i_ctrl.prev_valid;
        refresh   = 1'b0;
        sleep_req = 1'b0;
        mode      = i_ctrl.mode;

        case (i_ctrl.mode)
            tgrt_pkg::MODE_READY: begin
                if (first || i_ctrl.prev_mode != i_ctrl.mode) refresh = 1'b1;
                if (pend[0]) begin
                    pend    = pend & ~tgrt_pkg::PEND_START;
                    mode    = tgrt_pkg::MODE_RUNNING;
                    refresh = 1'b1;
                end
                if (show_edge) begin
                    mode    = tgrt_pkg::MODE_BEST;
                    refresh = 1'b1;
                end
            end
            tgrt_pkg::MODE_RUNNING: begin
                refresh = 1'b1;
                if (pend[0]) begin
                    pend     = pend & ~tgrt_pkg::PEND_START;
                    last_act = now;
                end
                if (pend[1]) begin
                    pend = pend & ~tgrt_pkg::PEND_FINISH;
                    if (last_res < best || best == '0) begin
                        best = last_res;
                        mode = tgrt_pkg::MODE_BEST;
                    end else begin
                        mode = tgrt_pkg::MODE_RESULT;
                    end
                end
            end
            tgrt_pkg::MODE_RESULT: begin
                if (first || i_ctrl.prev_mode != i_ctrl.mode) refresh = 1'b1;
                if (pend[0]) begin
                    pend = pend & ~tgrt_pkg::PEND_START;
                    mode = tgrt_pkg::MODE_RUNNING;
                end
                if (show_edge) begin
                    mode    = tgrt_pkg::MODE_BEST;
                    refresh = 1'b1;
                end
            end
            default: begin
                if (first || i_ctrl.prev_mode != i_ctrl.mode) refresh = 1'b1;
                if (pend[0]) begin
                    pend    = pend & ~tgrt_pkg::PEND_START;
                    mode    = tgrt_pkg::MODE_RUNNING;
                    refresh = 1'b1;
                end
                if (show_edge) begin
                    mode    = (best != '0) ? tgrt_pkg::MODE_RESULT : tgrt_pkg::MODE_READY;
                    refresh = 1'b1;
                end
                if (clear_edge) begin
                    best    = '0;
                    refresh = 1'b1;
                end
            end
        endcase

        if (sleep_edge) begin
            mode      = tgrt_pkg::MODE_READY;
            pend      = tgrt_pkg::PEND_NONE;
            last_act  = now;
            sleep_req = 1'b1;
            refresh   = 1'b1;
        end
        if (first || i_ctrl.prev_mode != mode) begin
            last_act = now;
            refresh  = 1'b1;
        end

        // Idle timeout; a fresh activity mark leaves a zero gap
        idle_gap = now - last_act;
        if (CW'(idle_gap) > CW'(i_idle_timeout)) begin
            mode      = tgrt_pkg::MODE_READY;
            pend      = tgrt_pkg::PEND_NONE;
            last_act  = now;
            sleep_req = 1'b1;
            refresh   = 1'b1;
        end

        case (mode)
            tgrt_pkg::MODE_RUNNING: shown = now - start_t;
            tgrt_pkg::MODE_RESULT:  shown = last_res;
            tgrt_pkg::MODE_BEST:    shown = best;
            default:                shown = '0;
        endcase
        shown_ext = CW'(shown);
        best_ext  = CW'(best);

        o_ctrl.mode       = mode;
        o_ctrl.prev_valid = 1'b1;
        o_ctrl.prev_mode  = mode;
        o_ctrl.pend       = pend;
        o_ctrl.btn_prev   = {i_item.sleep_button, i_item.clear_button, i_item.show_button};

        o_start_time  = start_t;
        o_last_result = last_res;
        o_best        = best;
        o_last_gate   = last_gate;
        o_last_act    = last_act;

        o_result.mode          = mode;
        o_result.shown_time_ms = shown_ext[tgrt_pkg::OUT_TIME_W-1:0];
        o_result.best_time_ms  = best_ext[tgrt_pkg::OUT_TIME_W-1:0];
        o_result.refresh       = refresh;
        o_result.sleep_request = sleep_req;
    end

endmodule

>>> test/tb_two_gate_race_timer.sv
module tb_two_gate_race_timer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LATENCY      = 2;       // input handshake to result valid
    localparam int unsigned RESET_CYCLES = 3;
    localparam int unsigned LIMIT_CYCLES = 200000;  // far beyond the slowest correct run
    localparam int unsigned PCT_IDLE     = 26;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [tgrt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tgrt_pkg::CFG_DATA_W-1:0] cfg_data;

    tgrt_in_if  item_if ();
    tgrt_out_if res_if ();

    two_gate_race_timer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Stopwatch shadow state: advanced once per accepted tick beat.
    logic [tgrt_pkg::LOCKOUT_W-1:0] sw_lockout;
    logic [tgrt_pkg::TIMEOUT_W-1:0] sw_timeout;
    logic [31:0]                    sw_now;
    logic [31:0]                    sw_start;
    logic [31:0]                    sw_last;
    logic [31:0]                    sw_best;
    logic [31:0]                    sw_gate;
    logic [31:0]                    sw_activity;
    tgrt_pkg::t_mode                sw_mode;
    tgrt_pkg::t_mode                sw_prev_mode;
    logic                           sw_prev_valid;
    logic [1:0]                     sw_pend;
    logic [2:0]                     sw_buttons;   // sleep, clear, show

    // Display beats still owed by the block, oldest first.
    tgrt_pkg::t_result display_queue [$];
    int unsigned       mismatches = 0;
    int unsigned       ticks_sent = 0;
    int unsigned       cycle_count = 0;
    bit                quiet = 1'b0;          // set to suppress all idling on both sides

    function automatic tgrt_pkg::t_item make_tick(input logic sg, input logic fg,
                                                  input logic sh, input logic cl,
                                                  input logic sl);
        return tgrt_pkg::t_item'{sg, fg, sh, cl, sl};
    endfunction

    // Advance the shadow stopwatch by one millisecond tick and return the display beat.
    task automatic stopwatch_tick(input tgrt_pkg::t_item it, output tgrt_pkg::t_result disp);
        logic [31:0]     now;
        logic            show_e, clear_e, sleep_e, first, refresh, sleep_req;
        tgrt_pkg::t_mode entry_mode;
        logic [31:0]     shown;
        now        = sw_now;
        refresh    = 1'b0;
        sleep_req  = 1'b0;
        first      = !sw_prev_valid;
        entry_mode = sw_mode;

        // Gate pulses: start is judged first, so a same-tick finish falls in the lockout.
        if (it.start_gate && (now - sw_gate) > 32'(sw_lockout)) begin
            sw_pend  = tgrt_pkg::PEND_START;          // drop any pending finish
            sw_start = now;
            sw_gate  = now;
        end
        if (it.finish_gate && (now - sw_gate) > 32'(sw_lockout)) begin
            sw_pend = sw_pend | tgrt_pkg::PEND_FINISH;
            sw_last = now - sw_start;
            sw_gate = now;
        end

        show_e     = it.show_button && !sw_buttons[0];
        clear_e    = it.clear_button && !sw_buttons[1];
        sleep_e    = !it.sleep_button && sw_buttons[2];
        sw_buttons = {it.sleep_button, it.clear_button, it.show_button};

        case (entry_mode)
            tgrt_pkg::MODE_READY: begin
                if (first || sw_prev_mode != entry_mode) refresh = 1'b1;
                if (sw_pend[0]) begin
                    sw_pend[0] = 1'b0;
                    sw_mode    = tgrt_pkg::MODE_RUNNING;
                    refresh    = 1'b1;
                end
                if (show_e) begin
                    sw_mode = tgrt_pkg::MODE_BEST;
                    refresh = 1'b1;
                end
            end
            tgrt_pkg::MODE_RUNNING: begin
                refresh = 1'b1;
                if (sw_pend[0]) begin
                    sw_pend[0]  = 1'b0;
                    sw_activity = now;
                end
                if (sw_pend[1]) begin
                    sw_pend[1] = 1'b0;
                    if (sw_last < sw_best || sw_best == 0) begin
                        sw_best = sw_last;
                        sw_mode = tgrt_pkg::MODE_BEST;
                    end else begin
                        sw_mode = tgrt_pkg::MODE_RESULT;
                    end
                end
            end
            tgrt_pkg::MODE_RESULT: begin
                if (first || sw_prev_mode != entry_mode) refresh = 1'b1;
                if (sw_pend[0]) begin
                    sw_pend[0] = 1'b0;
                    sw_mode    = tgrt_pkg::MODE_RUNNING;
                end
                if (show_e) begin
                    sw_mode = tgrt_pkg::MODE_BEST;
                    refresh = 1'b1;
                end
            end
            default: begin
                if (first || sw_prev_mode != entry_mode) refresh = 1'b1;
                if (sw_pend[0]) begin
                    sw_pend[0] = 1'b0;
                    sw_mode    = tgrt_pkg::MODE_RUNNING;
                    refresh    = 1'b1;
                end
                if (show_e) begin
                    sw_mode = (sw_best > 0) ? tgrt_pkg::MODE_RESULT : tgrt_pkg::MODE_READY;
                    refresh = 1'b1;
                end
                if (clear_e) begin
                    sw_best = '0;
                    refresh = 1'b1;
                end
            end
        endcase

        if (sleep_e) begin
            sw_mode     = tgrt_pkg::MODE_READY;
            sw_pend     = tgrt_pkg::PEND_NONE;
            sw_activity = now;
            sleep_req   = 1'b1;
            refresh     = 1'b1;
        end
        if (first || sw_prev_mode != sw_mode) begin
            sw_activity = now;
            refresh     = 1'b1;
        end
        // Only one sleep per tick: a button sleep has just reset the activity time.
        if ((now - sw_activity) > sw_timeout) begin
            sw_mode     = tgrt_pkg::MODE_READY;
            sw_pend     = tgrt_pkg::PEND_NONE;
            sw_activity = now;
            sleep_req   = 1'b1;
            refresh     = 1'b1;
        end

        sw_prev_valid = 1'b1;
        sw_prev_mode  = sw_mode;
        sw_now        = now + 1;

        case (sw_mode)
            tgrt_pkg::MODE_RUNNING: shown = now - sw_start;
            tgrt_pkg::MODE_RESULT:  shown = sw_last;
            tgrt_pkg::MODE_BEST:    shown = sw_best;
            default:                shown = '0;
        endcase
        disp = tgrt_pkg::t_result'{sw_mode, shown, sw_best, refresh, sleep_req};
    endtask

    // Drive one tick beat, with random idle cycles ahead of it, and log its display beat.
    task automatic send_tick(input tgrt_pkg::t_item it);
        tgrt_pkg::t_result disp;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < PCT_IDLE) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.start_gate   <= it.start_gate;
        item_if.finish_gate  <= it.finish_gate;
        item_if.show_button  <= it.show_button;
        item_if.clear_button <= it.clear_button;
        item_if.sleep_button <= it.sleep_button;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        stopwatch_tick(it, disp);
        display_queue.push_back(disp);
        ticks_sent++;
    endtask

    // Hold the sender until every display beat is back and the pipeline is empty.
    task automatic wait_idle();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (display_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tgrt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tgrt_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        if (idx == tgrt_pkg::CFG_GATE_LOCKOUT) sw_lockout = val[tgrt_pkg::LOCKOUT_W-1:0];
        else                                   sw_timeout = val[tgrt_pkg::TIMEOUT_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [tgrt_pkg::CFG_DATA_W-1:0] lockout,
                             input logic [tgrt_pkg::CFG_DATA_W-1:0] timeout);
        wait_idle();
        write_reg(tgrt_pkg::CFG_GATE_LOCKOUT, lockout);
        write_reg(tgrt_pkg::CFG_IDLE_TIMEOUT, timeout);
    endtask

    // Defaults after reset: 100 ms lockout rejects early gates, first tick redraws.
    task automatic test_power_on();
        send_tick(make_tick(1, 1, 0, 0, 0));
        send_tick(make_tick(0, 0, 1, 0, 0));
        send_tick(make_tick(0, 1, 0, 1, 1));
    endtask

    // Zero lockout: same-tick gates, start with view press, stray finish, clear best.
    task automatic test_gate_sequences();
        configure(32'd0, 32'd1000);
        send_tick(make_tick(1, 1, 0, 0, 0));   // start wins, finish locked out
        send_tick(make_tick(0, 0, 0, 0, 0));
        send_tick(make_tick(0, 1, 0, 0, 0));   // first result becomes best
        send_tick(make_tick(1, 0, 1, 0, 0));   // start then view: view decides
        send_tick(make_tick(0, 1, 0, 0, 0));   // finish outside running stays pending
        send_tick(make_tick(0, 0, 1, 1, 0));   // clear edge outside best is lost
        send_tick(make_tick(0, 0, 0, 1, 0));
        send_tick(make_tick(0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 1, 0));   // clear best
        send_tick(make_tick(1, 0, 0, 0, 0));   // start drops the stale finish
        send_tick(make_tick(0, 0, 0, 0, 0));
        send_tick(make_tick(0, 1, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 1));
        send_tick(make_tick(0, 0, 0, 0, 0));   // release: sleep
    endtask

    // Zero timeout makes button release and timeout land on one tick;
    // a short timeout then cuts a running race.
    task automatic test_idle_timeout();
        configure(32'd0, 32'd0);
        send_tick(make_tick(0, 0, 0, 0, 1));
        send_tick(make_tick(0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 1, 0, 0));
        configure(32'd0, 32'd4);
        send_tick(make_tick(1, 0, 0, 0, 0));
        repeat (5) send_tick(make_tick(0, 0, 0, 0, 0));
    endtask

    // Widest values; upper data bits of the lockout write are dropped.
    task automatic test_register_limits();
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(make_tick(1, 0, 0, 0, 0));
        send_tick(make_tick(0, 1, 0, 0, 0));
    endtask

    // One race: clear the lockout, start, wait out the lockout, finish, play with buttons; else random beats.
    task automatic random_race();
        int unsigned extra;
        if ($urandom_range(99) < 85) begin
            while ($urandom_range(3) != 0 && (sw_now - sw_gate) <= 32'(sw_lockout))
                send_tick(make_tick(0, 0, 0, 0, 0));
            send_tick(make_tick(1, $urandom_range(7) == 0, $urandom_range(7) == 0, 0, 0));
            extra = $urandom_range(4);
            // Stray gates inside the lockout must be ignored.
            while ((sw_now - sw_gate) <= 32'(sw_lockout))
                send_tick(make_tick($urandom_range(5) == 0, $urandom_range(5) == 0,
                                    $urandom_range(9) == 0, 0, 0));
            repeat (extra) send_tick(make_tick(0, 0, 0, 0, 0));
            send_tick(make_tick(0, 1, 0, 0, 0));
            repeat ($urandom_range(1, 3))
                send_tick(make_tick(0, 0, 1'($urandom_range(1)), $urandom_range(2) == 0, 0));
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 2)) send_tick(make_tick(0, 0, 0, 0, 1));
                send_tick(make_tick(0, 0, 0, 0, 0));
            end
        end else begin
            repeat ($urandom_range(1, 6)) send_tick(tgrt_pkg::t_item'(5'($urandom)));
        end
    endtask

    task automatic test_random_races();
        logic [tgrt_pkg::CFG_DATA_W-1:0] lockout, timeout;
        int unsigned target;
        for (int phase = 0; phase < 6; phase++) begin
            lockout = (phase == 0) ? 32'd0 : 32'($urandom_range(1, 10));
            case (phase)
                1:       timeout = 32'($urandom_range(3, 12));
                4:       timeout = 32'hFFFF_FFFF;
                default: timeout = 32'($urandom_range(40, 400));
            endcase
            configure(lockout, timeout);
            quiet  = (phase == 2);
            target = ticks_sent + 100;
            while (ticks_sent < target) begin
                random_race();
                // Hold the sender mid-phase until the whole backlog has drained.
                if (phase == 3 && ticks_sent + 50 >= target && ticks_sent + 40 < target)
                    wait_idle();
            end
            quiet = 1'b0;
        end
    endtask

    // Receiver: stall at random, except in the quiet stretch.
    always @(negedge i_clk) res_if.ready <= quiet || ($urandom_range(99) >= PCT_IDLE);

    // Compare every accepted display beat with the oldest expectation.
    // Fields are reported as mode, shown time, best time, refresh, sleep.
    always @(posedge i_clk) begin
        tgrt_pkg::t_result got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = tgrt_pkg::t_result'{res_if.mode, res_if.shown_time_ms, res_if.best_time_ms,
                                      res_if.refresh, res_if.sleep_request};
            if (display_queue.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat: actual %0d %0d %0d %0b %0b",
                         $realtime, got.mode, got.shown_time_ms, got.best_time_ms,
                         got.refresh, got.sleep_request);
            end else begin
                want = display_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: mismatch: expected %0d %0d %0d %0b %0b, actual %0d %0d %0d %0b %0b",
                             $realtime, want.mode, want.shown_time_ms, want.best_time_ms,
                             want.refresh, want.sleep_request, got.mode, got.shown_time_ms,
                             got.best_time_ms, got.refresh, got.sleep_request);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = tgrt_pkg::CFG_GATE_LOCKOUT;
        cfg_data             = '0;
        item_if.valid        = 1'b0;
        item_if.start_gate   = 1'b0;
        item_if.finish_gate  = 1'b0;
        item_if.show_button  = 1'b0;
        item_if.clear_button = 1'b0;
        item_if.sleep_button = 1'b0;

        // Shadow state starts where reset leaves the block.
        sw_lockout    = tgrt_pkg::LOCKOUT_RESET;
        sw_timeout    = tgrt_pkg::TIMEOUT_RESET;
        sw_now        = '0;
        sw_start      = '0;
        sw_last       = '0;
        sw_best       = '0;
        sw_gate       = '0;
        sw_activity   = '0;
        sw_mode       = tgrt_pkg::MODE_READY;
        sw_prev_mode  = tgrt_pkg::MODE_READY;
        sw_prev_valid = 1'b0;
        sw_pend       = tgrt_pkg::PEND_NONE;
        sw_buttons    = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on();
        test_gate_sequences();
        test_idle_timeout();
        test_register_limits();
        test_random_races();

        wait_idle();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
